FILE: rtl/baro_temp_pressure_compensation_unit_assert.svh
// ---------------------------------------------------------------------------
// assertion macros for the compensation unit
// clocked on clk, quiet while rst_n is low
// ---------------------------------------------------------------------------
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_UNIT_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_UNIT_ASSERT_SVH

// same-cycle implication
`define BTPC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define BTPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/btpc_pkg.sv
// ---------------------------------------------------------------------------
// btpc_pkg
// word types, trim bundle and helper functions of the compensation unit
// ---------------------------------------------------------------------------
package btpc_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    REG_TRIM_TEMP       = 2'd0,
    REG_TRIM_PRESS_LOW  = 2'd1,
    REG_TRIM_PRESS_HIGH = 2'd2,
    REG_TRIM_P9         = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_pascal;
    logic               divisor_zero;
  } out_word_t;

  typedef struct packed {
    logic [47:0] trim_temp;
    logic [63:0] trim_press_low;
    logic [63:0] trim_press_high;
    logic [15:0] trim_p9;
  } trims_t;

  function automatic logic [31:0] sra32(input logic [31:0] x, input logic [4:0] n);
    sra32 = 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sext16(input logic [15:0] h);
    sext16 = {{16{h[15]}}, h};
  endfunction

endpackage

FILE: rtl/btpc_queue.sv
// ---------------------------------------------------------------------------
// btpc_queue
// front end: takes input words and holds them for the arithmetic core
// ---------------------------------------------------------------------------
module btpc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  btpc_pkg::in_word_t in_word,
  output logic              q_valid,
  output btpc_pkg::in_word_t q_word,
  input  logic              q_pop
);
  import btpc_pkg::*;

  in_word_t  mem_r [QueueDepth];
  logic      rd_ptr_r, wr_ptr_r;
  logic [1:0] count_r;
  logic      push, pop;

  assign in_stall = (count_r == 2'(QueueDepth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_word   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end
endmodule

FILE: rtl/btpc_core.sv
// ---------------------------------------------------------------------------
// btpc_core
// back end: sequenced compensation arithmetic on one shared multiplier
// and a two-bit-per-cycle divider
// ---------------------------------------------------------------------------
`include "baro_temp_pressure_compensation_unit_assert.svh"

module btpc_core (
  input  logic               clk,
  input  logic               rst_n,
  input  btpc_pkg::trims_t   trims,
  input  logic               q_valid,
  input  btpc_pkg::in_word_t q_word,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output btpc_pkg::out_word_t out_word
);
  import btpc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_T0, S_T1, S_T2, S_T3, S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6,
    S_DIV, S_DFIN, S_Q0, S_Q1, S_Q2, S_DONE
  } state_t;

  state_t      state_r;
  logic [19:0] adc_t_r, adc_p_r;
  logic [31:0] a_r, x_r, temp_r, v1_r, qq_r, v2_r, dv_r, src_r, quo_r, p_r;
  logic [31:0] rem_r;
  logic [3:0]  cnt_r;
  logic        post_r, zero_r, out_valid_r;
  out_word_t   out_r;

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] mul_a, mul_b, mul_p;
  logic [32:0] rem1, rem2;
  logic        qb1, qb2;

  assign t1 = {16'd0, trims.trim_temp[15:0]};
  assign t2 = sext16(trims.trim_temp[31:16]);
  assign t3 = sext16(trims.trim_temp[47:32]);
  assign p1 = {16'd0, trims.trim_press_low[15:0]};
  assign p2 = sext16(trims.trim_press_low[31:16]);
  assign p3 = sext16(trims.trim_press_low[47:32]);
  assign p4 = sext16(trims.trim_press_low[63:48]);
  assign p5 = sext16(trims.trim_press_high[15:0]);
  assign p6 = sext16(trims.trim_press_high[31:16]);
  assign p7 = sext16(trims.trim_press_high[47:32]);
  assign p8 = sext16(trims.trim_press_high[63:48]);
  assign p9 = sext16(trims.trim_p9);

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state_r)
      S_T0: begin
        mul_a = {15'd0, adc_t_r[19:3]} - (t1 << 1);
        mul_b = t2;
      end
      S_T1: begin
        mul_a = {16'd0, adc_t_r[19:4]} - t1;
        mul_b = {16'd0, adc_t_r[19:4]} - t1;
      end
      S_T2: begin
        mul_a = x_r;
        mul_b = t3;
      end
      S_T3: begin
        mul_a = a_r;
        mul_b = 32'd5;
      end
      S_P0: begin
        mul_a = sra32(v1_r, 5'd2);
        mul_b = sra32(v1_r, 5'd2);
      end
      S_P1: begin
        mul_a = sra32(qq_r, 5'd11);
        mul_b = p6;
      end
      S_P2: begin
        mul_a = v1_r;
        mul_b = p5;
      end
      S_P3: begin
        mul_a = p3;
        mul_b = sra32(qq_r, 5'd13);
      end
      S_P4: begin
        mul_a = p2;
        mul_b = v1_r;
      end
      S_P5: begin
        mul_a = 32'd32768 + x_r;
        mul_b = p1;
      end
      S_P6: begin
        mul_a = (32'd1048576 - {12'd0, adc_p_r}) - sra32(v2_r, 5'd12);
        mul_b = 32'd3125;
      end
      S_Q0: begin
        mul_a = p_r >> 3;
        mul_b = p_r >> 3;
      end
      S_Q1: begin
        mul_a = p9;
        mul_b = x_r;
      end
      S_Q2: begin
        mul_a = p_r >> 2;
        mul_b = p8;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // two restoring division steps
  always_comb begin
    rem1 = {rem_r, src_r[31]};
    qb1  = (rem1 >= {1'b0, dv_r});
    if (qb1) begin
      rem1 = rem1 - {1'b0, dv_r};
    end
    rem2 = {rem1[31:0], src_r[30]};
    qb2  = (rem2 >= {1'b0, dv_r});
    if (qb2) begin
      rem2 = rem2 - {1'b0, dv_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            adc_t_r <= q_word.raw_temperature;
            adc_p_r <= q_word.raw_pressure;
            state_r <= S_T0;
          end
        end
        S_T0: begin
          a_r     <= sra32(mul_p, 5'd11);
          state_r <= S_T1;
        end
        S_T1: begin
          x_r     <= sra32(mul_p, 5'd12);
          state_r <= S_T2;
        end
        S_T2: begin
          // fine temperature
          a_r     <= a_r + sra32(mul_p, 5'd14);
          state_r <= S_T3;
        end
        S_T3: begin
          temp_r  <= sra32(mul_p + 32'd128, 5'd8);
          v1_r    <= sra32(a_r, 5'd1) - 32'd64000;
          state_r <= S_P0;
        end
        S_P0: begin
          qq_r    <= mul_p;
          state_r <= S_P1;
        end
        S_P1: begin
          v2_r    <= mul_p;
          state_r <= S_P2;
        end
        S_P2: begin
          v2_r    <= sra32(v2_r + (mul_p << 1), 5'd2) + (p4 << 16);
          state_r <= S_P3;
        end
        S_P3: begin
          x_r     <= sra32(mul_p, 5'd3);
          state_r <= S_P4;
        end
        S_P4: begin
          x_r     <= sra32(x_r + sra32(mul_p, 5'd1), 5'd18);
          state_r <= S_P5;
        end
        S_P5: begin
          dv_r    <= sra32(mul_p, 5'd15);
          state_r <= S_P6;
        end
        S_P6: begin
          rem_r <= 32'd0;
          cnt_r <= 4'd0;
          if (dv_r == 32'd0) begin
            zero_r  <= 1'b1;
            p_r     <= 32'd0;
            state_r <= S_DONE;
          end else begin
            zero_r <= 1'b0;
            if (!mul_p[31]) begin
              src_r  <= mul_p << 1;
              post_r <= 1'b0;
            end else begin
              src_r  <= mul_p;
              post_r <= 1'b1;
            end
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= rem2[31:0];
          src_r <= src_r << 2;
          quo_r <= {quo_r[29:0], qb1, qb2};
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            state_r <= S_DFIN;
          end
        end
        S_DFIN: begin
          p_r     <= post_r ? (quo_r << 1) : quo_r;
          state_r <= S_Q0;
        end
        S_Q0: begin
          x_r     <= mul_p >> 13;
          state_r <= S_Q1;
        end
        S_Q1: begin
          a_r     <= sra32(mul_p, 5'd12);
          state_r <= S_Q2;
        end
        S_Q2: begin
          p_r     <= p_r + sra32(a_r + sra32(mul_p, 5'd13) + p7, 5'd4);
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_r.temperature_centi <= temp_r;
            out_r.pressure_pascal   <= p_r;
            out_r.divisor_zero      <= zero_r;
            state_r                 <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `BTPC_ASSERT_SAME(a_zero_flag, out_valid_r && out_r.divisor_zero, out_r.pressure_pascal == 32'd0)
  `BTPC_ASSERT_SAME(a_pop_idle, q_pop, state_r == S_IDLE)
  `BTPC_ASSERT_NEXT(a_div_leave, state_r == S_DIV && cnt_r == 4'd15, state_r == S_DFIN)
  `BTPC_ASSERT_NEXT(a_held_result, out_valid_r && out_stall, out_valid_r)
endmodule

FILE: rtl/baro_temp_pressure_compensation_unit.sv
// ---------------------------------------------------------------------------
// baro_temp_pressure_compensation_unit
// 32-bit integer temperature and pressure compensation from raw conversions
// ---------------------------------------------------------------------------
// each word runs through the back end on one shared 32x32 multiplier,
// used up to fourteen times in sequence, and a divider giving two quotient
// bits a cycle (a zero divisor skips the division and the steps after it);
// a two-word queue in front and a result register behind let input and
// output flow while a word is being worked on
module baro_temp_pressure_compensation_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  btpc_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output btpc_pkg::out_word_t out_word
);
  import btpc_pkg::*;

  trims_t   trims_r;
  logic     q_valid, q_pop;
  in_word_t q_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trims_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRIM_TEMP:       trims_r.trim_temp       <= cfg_data[47:0];
        REG_TRIM_PRESS_LOW:  trims_r.trim_press_low  <= cfg_data;
        REG_TRIM_PRESS_HIGH: trims_r.trim_press_high <= cfg_data;
        REG_TRIM_P9:         trims_r.trim_p9         <= cfg_data[15:0];
        default:             trims_r                 <= trims_r;
      endcase
    end
  end

  btpc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_valid  (q_valid),
    .q_word   (q_word),
    .q_pop    (q_pop)
  );

  btpc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .trims     (trims_r),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );
endmodule
